// ===== sv/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared widths, operation and status codes, and the empty-end marker word.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int unsigned DQ_DEPTH   = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned ITEM_CNT_W = 5;

    // Result payload: popped word, front word, back word and count,
    // padded with zeros up to whole bytes.
    localparam int unsigned RES_BITS   = 3 * WORD_W + ITEM_CNT_W;
    localparam int unsigned RES_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Reported at both ends when nothing is held.
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

endpackage

// ===== sv/dq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// A bounded deque of signed 32-bit words kept in a ring buffer in RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit up)                      tuser
//  s_axis    in         value[31:0]                             mode[1:0]
//  m_axis    out        popped, front, back, item_count, pad    status[1:0]
//
// A push request's result is in the output register on the cycle after
// acceptance, and a new request can be taken every cycle while results are taken.
// A pop request reads the new end word from the word RAM, whose read data
// is registered, and forms its result in state S_READ; no request is taken
// meanwhile. A result that waits on m_axis blocks new requests; one enters
// on the cycle that the waiting result is taken. Reset (synchronous, active
// low) empties the deque; the RAM is not cleared.
//
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH = DQ_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [WORD_W-1:0]     s_axis_tdata,   // value[31:0]
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode[1:0]

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // popped_value[31:0], front_value[63:32], back_value[95:64],
    // item_count[100:96], zero padding above
    output logic [RES_DATA_W-1:0] m_axis_tdata,
    output logic [STATUS_W-1:0]   m_axis_tuser    // status[1:0]
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Two-state control: either ready for a request, or waiting on the RAM.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
        return (x == LAST_IDX) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
        return (x == '0) ? LAST_IDX : x - AW'(1);
    endfunction

    // Control state. The tail points at the back word, so with nothing held
    // it sits one place before the head.
    t_state          r_state,  n_state;
    logic [AW-1:0]   r_head,   n_head;
    logic [AW-1:0]   r_tail,   n_tail;
    logic [CW-1:0]   r_count,  n_count;
    logic            r_out_vld, n_out_vld;

    // The end words are cached so only a pop needs a RAM read.
    logic [WORD_W-1:0] r_front_word, n_front_word;
    logic [WORD_W-1:0] r_back_word,  n_back_word;

    // Pending pop, remembered across the RAM read.
    logic              r_pend_front, n_pend_front;
    logic [WORD_W-1:0] r_pend_pop,   n_pend_pop;

    // Result register.
    t_status           r_status,    n_status;
    logic [WORD_W-1:0] r_out_pop,   n_out_pop;
    logic [WORD_W-1:0] r_out_front, n_out_front;
    logic [WORD_W-1:0] r_out_back,  n_out_back;
    logic [CW-1:0]     r_out_cnt,   n_out_cnt;

    logic              accept;
    t_mode             req_mode;
    logic              is_full;
    logic              is_empty;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A request enters only when no pop is in flight and the result register
    // is free or being drained this cycle.
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_vld || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req_mode      = t_mode'(s_axis_tuser);
    assign is_full       = (r_count == FULL_CNT);
    assign is_empty      = (r_count == '0);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front_word = r_front_word;
        n_back_word  = r_back_word;
        n_pend_front = r_pend_front;
        n_pend_pop   = r_pend_pop;
        n_status     = r_status;
        n_out_pop    = r_out_pop;
        n_out_front  = r_out_front;
        n_out_back   = r_out_back;
        n_out_cnt    = r_out_cnt;
        n_out_vld    = r_out_vld && !m_axis_tready;
        ram_we       = 1'b0;
        ram_waddr    = r_tail;
        ram_re       = 1'b0;
        ram_raddr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (req_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            n_out_vld = 1'b1;
                            n_out_pop = '0;
                            if (is_full) begin
                                n_status    = ST_OVER;
                                n_out_front = r_front_word;
                                n_out_back  = r_back_word;
                                n_out_cnt   = r_count;
                            end else begin
                                ram_we   = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_status = ST_DONE;
                                if (req_mode == MODE_PUSH_FRONT) begin
                                    n_head       = idx_dec(r_head);
                                    ram_waddr    = n_head;
                                    n_front_word = s_axis_tdata;
                                    if (is_empty) begin
                                        n_back_word = s_axis_tdata;
                                    end
                                end else begin
                                    n_tail      = idx_inc(r_tail);
                                    ram_waddr   = n_tail;
                                    n_back_word = s_axis_tdata;
                                    if (is_empty) begin
                                        n_front_word = s_axis_tdata;
                                    end
                                end
                                n_out_front = n_front_word;
                                n_out_back  = n_back_word;
                                n_out_cnt   = n_count;
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                n_out_vld   = 1'b1;
                                n_status    = ST_UNDER;
                                n_out_pop   = '0;
                                n_out_front = EMPTY_WORD;
                                n_out_back  = EMPTY_WORD;
                                n_out_cnt   = r_count;
                            end else begin
                                // Fetch the word that becomes the new end.
                                ram_re       = 1'b1;
                                n_count      = r_count - CW'(1);
                                n_state      = S_READ;
                                n_pend_front = (req_mode == MODE_POP_FRONT);
                                if (req_mode == MODE_POP_FRONT) begin
                                    n_pend_pop = r_front_word;
                                    n_head     = idx_inc(r_head);
                                    ram_raddr  = n_head;
                                end else begin
                                    n_pend_pop = r_back_word;
                                    n_tail     = idx_dec(r_tail);
                                    ram_raddr  = n_tail;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                // The result register was drained when the pop was taken.
                n_state   = S_IDLE;
                n_out_vld = 1'b1;
                n_status  = ST_DONE;
                n_out_pop = r_pend_pop;
                n_out_cnt = r_count;
                if (r_pend_front) begin
                    n_front_word = ram_rdata;
                end else begin
                    n_back_word = ram_rdata;
                end
                if (r_count == '0) begin
                    n_out_front = EMPTY_WORD;
                    n_out_back  = EMPTY_WORD;
                end else begin
                    n_out_front = n_front_word;
                    n_out_back  = n_back_word;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= LAST_IDX;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_word <= n_front_word;
        r_back_word  <= n_back_word;
        r_pend_front <= n_pend_front;
        r_pend_pop   <= n_pend_pop;
        r_status     <= n_status;
        r_out_pop    <= n_out_pop;
        r_out_front  <= n_out_front;
        r_out_back   <= n_out_back;
        r_out_cnt    <= n_out_cnt;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = RES_DATA_W'({ITEM_CNT_W'(r_out_cnt), r_out_back,
                                        r_out_front, r_out_pop});

endmodule

// ===== test/double_ended_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push and pop requests at both ends of the deque over the input
// stream and checks every result word against a behavioral copy of the deque
// kept in this file. A short table of hand-picked requests comes first, most
// of them with hand-written results; random requests follow, in phases that
// lean towards pushing or popping so that the fill level sweeps from empty to
// full. Both stream sides idle at random, and once the output side holds off
// long enough for the deque to stop taking requests.
// ----------------------------------------------------------------------------
module double_ended_queue_test
    import dq_pkg::*;
();

    // Number of random requests after the table.
    localparam int unsigned RANDOM_REQUESTS = 1720;

    // The output side holds off for this many cycles once during the run.
    localparam int unsigned HOLDOFF_CYCLES = 120;
    localparam int unsigned HOLDOFF_AT = 300;

    // A pop passes through the RAM read and then the output register, so this
    // margin is plenty to catch any stray result after the last expected one.
    localparam int unsigned DRAIN_CYCLES = 10;

    // Slowest correct run: about 1750 requests, each held up by the block, by a
    // sender gap and by output stalls, plus the one long hold-off. The limit
    // leaves a wide margin on top of that.
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  popped;
        logic [WORD_W-1:0]  front;
        logic [WORD_W-1:0]  back;
        logic [ITEM_CNT_W-1:0] count;
    } t_deque_result;

    // One row of the directed table. A row may repeat its request; rows with
    // a hand-written result carry it in want.
    typedef struct {
        t_mode              op;
        logic [WORD_W-1:0]  word;
        int unsigned        reps;
        bit                 known;
        t_deque_result      want;
    } t_stim_row;

    // Receiver behavior during one stretch of cycles.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata = '0;              // value[31:0]
    logic [MODE_W-1:0]     s_axis_tuser = MODE_PUSH_FRONT; // mode[1:0]

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // popped_value[31:0], front_value[63:32], back_value[95:64],
    // item_count[100:96], zero padding above
    logic [RES_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;                   // status[1:0]

    double_ended_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the deque. Words live in a ring; the front is at
    // deque_head and the k-th word behind it at (deque_head + k) mod depth.
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0] deque_words [DQ_DEPTH];
    int unsigned       deque_head = 0;
    int unsigned       deque_held = 0;

    // Results still owed by the block, oldest first.
    t_deque_result     awaited_results [$];

    // The directed table, walked in order.
    t_stim_row         directed_rows [$];

    // Run statistics for the closing summary.
    int unsigned       accepted_requests = 0;
    int unsigned       push_count = 0;
    int unsigned       pop_count = 0;
    int unsigned       overflow_count = 0;
    int unsigned       underflow_count = 0;
    int unsigned       full_hits = 0;
    int unsigned       checked_results = 0;

    int unsigned       fault_count = 0;
    int unsigned       cycle_count = 0;

    // Set by the sender, taken up by the receiver: start the long hold-off.
    bit                holdoff_pending = 1'b0;

    function automatic int unsigned ring_slot(input int unsigned offset);
        return (deque_head + offset) % DQ_DEPTH;
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void add_row(input t_stim_row row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Applies one request to the behavioral deque and returns the result the
    // block must produce for it.
    function automatic t_deque_result deque_apply(input t_mode op,
                                                  input logic [WORD_W-1:0] word);
        t_deque_result r;
        r.status = ST_DONE;
        r.popped = '0;
        case (op)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                // A push into a full deque drops the word and changes nothing.
                if (deque_held >= DQ_DEPTH) begin
                    r.status = ST_OVER;
                end else if (op == MODE_PUSH_FRONT) begin
                    deque_head = (deque_head + DQ_DEPTH - 1) % DQ_DEPTH;
                    deque_words[deque_head] = word;
                    deque_held++;
                end else begin
                    deque_words[ring_slot(deque_held)] = word;
                    deque_held++;
                end
            end
            default: begin
                // A pop from an empty deque reports underflow and pops zero.
                if (deque_held == 0) begin
                    r.status = ST_UNDER;
                end else if (op == MODE_POP_FRONT) begin
                    r.popped = deque_words[deque_head];
                    deque_head = ring_slot(1);
                    deque_held--;
                end else begin
                    r.popped = deque_words[ring_slot(deque_held - 1)];
                    deque_held--;
                end
            end
        endcase
        if (deque_held == 0) begin
            r.front = EMPTY_WORD;
            r.back  = EMPTY_WORD;
        end else begin
            r.front = deque_words[deque_head];
            r.back  = deque_words[ring_slot(deque_held - 1)];
        end
        r.count = ITEM_CNT_W'(deque_held);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Requests go out in bursts of random length separated by random
    // gaps; a gap of zero joins two bursts into one unbroken stretch. Inputs
    // change only at the falling edge, once per edge.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic offer_request(input t_mode op, input logic [WORD_W-1:0] word,
                                 input bit known, input t_deque_result want);
        int unsigned   gap;
        t_deque_result predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        burst_left--;

        // The request was taken at this edge: advance the behavioral deque.
        predicted = deque_apply(op, word);
        awaited_results.insert(awaited_results.size(), known ? want : predicted);
        accepted_requests++;
        if (op == MODE_PUSH_FRONT || op == MODE_PUSH_BACK) begin
            push_count++;
        end else begin
            pop_count++;
        end
        if (predicted.status == ST_OVER) overflow_count++;
        if (predicted.status == ST_UNDER) underflow_count++;
        if (predicted.status == ST_DONE && deque_held == DQ_DEPTH) full_hits++;
    endtask

    // Table rows: one checked against the behavioral deque, one with its
    // result written out by hand.
    function automatic t_stim_row step_row(input t_mode op,
                                           input logic [WORD_W-1:0] word,
                                           input int unsigned reps);
        t_stim_row row;
        row.op    = op;
        row.word  = word;
        row.reps  = reps;
        row.known = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_stim_row checked_row(input t_mode op,
                                              input logic [WORD_W-1:0] word,
                                              input t_status status,
                                              input logic [WORD_W-1:0] popped,
                                              input logic [WORD_W-1:0] front,
                                              input logic [WORD_W-1:0] back,
                                              input logic [ITEM_CNT_W-1:0] count);
        t_stim_row row;
        row.op          = op;
        row.word        = word;
        row.reps        = 1;
        row.known       = 1'b1;
        row.want.status = status;
        row.want.popped = popped;
        row.want.front  = front;
        row.want.back   = back;
        row.want.count  = count;
        return row;
    endfunction

    // Mostly uniform words, with the extremes and the all-ones word mixed in
    // so that a stored -1 shows up at the ends now and then.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return EMPTY_WORD;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: reset, the directed table, then the random phases.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row     row;
        int unsigned   phase_left;
        int unsigned   push_pct;
        bit            is_push;
        bit            at_front;
        t_mode         op;

        // Reset held low from the start, released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty deque: both pops underflow and report the empty marker.
        add_row(checked_row(MODE_POP_FRONT, 32'h0000_0000,
            ST_UNDER, 32'h0, EMPTY_WORD, EMPTY_WORD, 5'd0));
        add_row(checked_row(MODE_POP_BACK, 32'hFFFF_FFFF,
            ST_UNDER, 32'h0, EMPTY_WORD, EMPTY_WORD, 5'd0));
        // Largest and smallest words at each end; the front push wraps the
        // head index below zero.
        add_row(checked_row(MODE_PUSH_BACK, 32'h7FFF_FFFF,
            ST_DONE, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1));
        add_row(checked_row(MODE_PUSH_FRONT, 32'h8000_0000,
            ST_DONE, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2));
        // A stored all-ones word looks like the empty marker at the back.
        add_row(checked_row(MODE_PUSH_BACK, 32'hFFFF_FFFF,
            ST_DONE, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 5'd3));
        add_row(checked_row(MODE_POP_FRONT, 32'h0000_0000,
            ST_DONE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd2));
        add_row(checked_row(MODE_POP_BACK, 32'h0000_0000,
            ST_DONE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1));
        add_row(checked_row(MODE_POP_BACK, 32'h0000_0000,
            ST_DONE, 32'h7FFF_FFFF, EMPTY_WORD, EMPTY_WORD, 5'd0));
        // One held all-ones word: only the count tells it from empty.
        add_row(checked_row(MODE_PUSH_FRONT, 32'hFFFF_FFFF,
            ST_DONE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1));
        add_row(checked_row(MODE_POP_FRONT, 32'h0000_0000,
            ST_DONE, 32'hFFFF_FFFF, EMPTY_WORD, EMPTY_WORD, 5'd0));
        // Fill to the brim, then push at both ends while full.
        add_row(step_row(MODE_PUSH_BACK, 32'h5555_5555, 15));
        add_row(checked_row(MODE_PUSH_FRONT, 32'hAAAA_AAAA,
            ST_DONE, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555, 5'd16));
        add_row(checked_row(MODE_PUSH_BACK, 32'h0000_0000,
            ST_OVER, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555, 5'd16));
        add_row(checked_row(MODE_PUSH_FRONT, 32'h1234_5678,
            ST_OVER, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555, 5'd16));
        add_row(checked_row(MODE_POP_FRONT, 32'h0000_0000,
            ST_DONE, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 5'd15));

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            repeat (row.reps) offer_request(row.op, row.word, row.known, row.want);
        end

        // Random phases. Each phase leans towards pushing, popping or neither,
        // so the fill level keeps crossing the whole range and both the full
        // and the empty deque are met many times.
        phase_left = 0;
        push_pct   = 50;
        for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            phase_left--;
            if (n == HOLDOFF_AT) holdoff_pending = 1'b1;

            is_push  = ($urandom_range(0, 99) < push_pct);
            at_front = $urandom_range(0, 1);
            if (is_push) begin
                op = at_front ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end else begin
                op = at_front ? MODE_POP_FRONT : MODE_POP_BACK;
            end
            // Pops carry a random word too; the block must ignore it.
            offer_request(op, random_word(), 1'b0, '0);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Wait for every owed result, then a few cycles for anything extra.
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d pushes, %0d pops), %0d results checked.",
                 accepted_requests, push_count, pop_count, checked_results);
        $display("Overflows %0d, underflows %0d, deque filled %0d times, faults %0d.",
                 overflow_count, underflow_count, full_hits, fault_count);
        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. The ready pattern changes style every stretch of random length:
    // always ready, ready at random, or ready on one cycle in a fixed period.
    // Once during the run it holds off for a long stretch while the sender
    // keeps offering, so a result waits and the block stalls its input.
    // ------------------------------------------------------------------------
    initial begin : receiver
        t_rx_style   style;
        int unsigned stretch_left;
        int unsigned period;
        int unsigned phase;
        int unsigned hold_left;
        style        = RX_STREAM;
        stretch_left = 0;
        period       = 2;
        phase        = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_pending) begin
                holdoff_pending = 1'b0;
                hold_left = HOLDOFF_CYCLES;
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 200);
                period       = $urandom_range(2, 4);
                case ($urandom_range(0, 2))
                    0:       style = RX_STREAM;
                    1:       style = RX_RANDOM;
                    default: style = RX_PERIODIC;
                endcase
            end
            stretch_left--;
            phase++;
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (style)
                    RX_STREAM:   m_axis_tready <= 1'b1;
                    RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 9) < 7);
                    RX_PERIODIC: m_axis_tready <= (phase % period == 0);
                    default:     m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Every accepted result is compared with the oldest owed
    // one; a result with nothing owed is a fault as well.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_deque_result got;
        t_deque_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tuser);
            got.popped = m_axis_tdata[WORD_W-1:0];
            got.front  = m_axis_tdata[2*WORD_W-1:WORD_W];
            got.back   = m_axis_tdata[3*WORD_W-1:2*WORD_W];
            got.count  = m_axis_tdata[3*WORD_W+ITEM_CNT_W-1:3*WORD_W];
            if (awaited_results.size() == 0) begin
                if (fault_count < 10) begin
                    $display("Result with no request outstanding: status %0d popped %h",
                             got.status, got.popped);
                end
                fault_count++;
            end else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                if (got !== want) begin
                    if (fault_count < 10) begin
                        $display("Result %0d wrong: expected st %0d pop %h fr %h bk %h n %0d",
                                 checked_results, want.status, want.popped, want.front,
                                 want.back, want.count);
                        $display("                  got      st %0d pop %h fr %h bk %h n %0d",
                                 got.status, got.popped, got.front, got.back, got.count);
                    end
                    fault_count++;
                end
                checked_results++;
            end
        end
    end

    // Run limit, counted in clock cycles.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results still owed.",
                 cycle_count, awaited_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
